FILE: rtl/book_entry_weighted_pick_top_defines.svh
// Assertion macros shared by the book entry weighted pick RTL.
`ifndef BOOK_ENTRY_WEIGHTED_PICK_TOP_DEFINES_SVH
`define BOOK_ENTRY_WEIGHTED_PICK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BEWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bewp: same-cycle check failed");
`define BEWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bewp: next-cycle check failed");
`else
`define BEWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BEWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/bewp_pkg.sv
// Types and constants of the book entry weighted pick block.
package bewp_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned MoveW    = 16;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned RandW    = 16;
  localparam int unsigned SumW     = 24;

  // key compare runs one digit per cycle
  localparam int unsigned DigitW    = 4;
  localparam int unsigned KeyDigits = KeyW / DigitW;
  localparam int unsigned DigitCntW = $clog2(KeyDigits);

  // serial modulo: one dividend bit per cycle
  localparam int unsigned ModW    = RandW;
  localparam int unsigned ModCntW = $clog2(ModW);

  // saturation point of the weight sum
  localparam int unsigned MaxEntriesPerKey = 256;
  localparam logic [31:0] SumCapRaw = 32'(MaxEntriesPerKey) * 32'd65535;
  localparam logic [SumW-1:0] SumCap =
    (SumCapRaw > 32'h00FF_FFFF) ? {SumW{1'b1}} : SumCapRaw[SumW-1:0];

  typedef struct packed {
    logic               first_of_probe;
    logic [KeyW-1:0]    target_key;
    logic [KeyW-1:0]    entry_key;
    logic [MoveW-1:0]   entry_move;
    logic [WeightW-1:0] entry_weight;
    logic               prefer_best;
    logic [RandW-1:0]   random_value;
  } in_word_t;

  typedef struct packed {
    logic [MoveW-1:0] chosen_move;
    logic             found;
    logic [SumW-1:0]  weight_total;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [ModW-1:0] dividend;
    logic [ModW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [ModW-1:0] remainder;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StUpd,
    StMod,
    StEmit
  } state_e;

endpackage

FILE: rtl/bewp_if.sv
// Valid/ready channels carrying entry words in and pick words out.
interface bewp_in_if;
  logic                valid;
  logic                ready;
  bewp_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bewp_out_if;
  logic                valid;
  logic                ready;
  bewp_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bewp_mod_unit.sv
// Bit-serial restoring modulo: remainder of a 16-bit dividend by a 16-bit divisor.
module bewp_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bewp_pkg::mod_req_t req_i,
  output bewp_pkg::mod_rsp_t rsp_o
);

  localparam int unsigned W  = bewp_pkg::ModW;
  localparam int unsigned CW = bewp_pkg::ModCntW;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  div_q, div_d;
  logic [W:0]    trial;

  // one restoring step per busy cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    trial  = {rem_q, dvd_q[W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[W-1:0];
      end
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: rtl/book_entry_weighted_pick_top.sv
// Book entry weighted pick: scans a key run and picks one move by weight.
// An ignored word leaves the block idle. A compared word runs a digit-serial key compare;
// a mismatch then emits the pick word, a matching null move returns to idle, and any other
// match takes the update step, in random mode with a serial modulo when the sum is 1..65535.
// One entry word is in flight at a time; the next is taken once the block is idle.
// Reset (rst_ni low, asynchronous) ends any probe and clears max, sum and kept move.
`include "book_entry_weighted_pick_top_defines.svh"

module book_entry_weighted_pick_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  bewp_in_if.sink  in_i,
  bewp_out_if.source out_o
);

  localparam int unsigned KeyW  = bewp_pkg::KeyW;
  localparam int unsigned DW    = bewp_pkg::DigitW;
  localparam int unsigned DCW   = bewp_pkg::DigitCntW;
  localparam int unsigned SumW  = bewp_pkg::SumW;
  localparam int unsigned WW    = bewp_pkg::WeightW;
  localparam int unsigned MW    = bewp_pkg::MoveW;
  localparam int unsigned RW    = bewp_pkg::RandW;
  localparam int unsigned ModW  = bewp_pkg::ModW;

  bewp_pkg::state_e state_q, state_d;

  // control and selection state
  logic             active_q, active_d;
  logic [WW-1:0]    max_q, max_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [MW-1:0]    kept_q, kept_d;
  logic [DCW-1:0]   cnt_q, cnt_d;
  logic             mism_q, mism_d;
  logic             out_valid_q, out_valid_d;

  // captured word payload
  logic [KeyW-1:0]  tkey_q, tkey_d;
  logic [KeyW-1:0]  ekey_q, ekey_d;
  logic [MW-1:0]    move_q, move_d;
  logic [WW-1:0]    weight_q, weight_d;
  logic             best_q, best_d;
  logic [RW-1:0]    rnd_q, rnd_d;
  bewp_pkg::out_word_t out_q, out_d;

  logic             in_fire;
  logic             out_load;
  logic             mism_now;
  logic [SumW:0]    sum_ext;
  logic [SumW-1:0]  new_sum;
  logic [WW-1:0]    new_max;

  bewp_pkg::mod_req_t mod_req;
  bewp_pkg::mod_rsp_t mod_rsp;

  bewp_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign in_i.ready  = (state_q == bewp_pkg::StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // saturating sum and running max for the update step
  assign sum_ext  = {1'b0, sum_q} + (SumW + 1)'(weight_q);
  assign new_sum  = (sum_ext > {1'b0, bewp_pkg::SumCap}) ? bewp_pkg::SumCap
                                                        : sum_ext[SumW-1:0];
  assign new_max  = (weight_q > max_q) ? weight_q : max_q;
  assign mism_now = mism_q || (tkey_q[DW-1:0] != ekey_q[DW-1:0]);

  // sequencer: capture, digit compare, update, modulo, emit
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    max_d       = max_q;
    sum_d       = sum_q;
    kept_d      = kept_q;
    cnt_d       = cnt_q;
    mism_d      = mism_q;
    tkey_d      = tkey_q;
    ekey_d      = ekey_q;
    move_d      = move_q;
    weight_d    = weight_q;
    best_d      = best_q;
    rnd_d       = rnd_q;
    out_d       = out_q;
    out_load    = 1'b0;
    mod_req     = '0;
    mod_req.dividend = rnd_q;
    mod_req.divisor  = new_sum[ModW-1:0];

    case (state_q)
      bewp_pkg::StIdle: begin
        if (in_fire) begin
          tkey_d   = in_i.data.target_key;
          ekey_d   = in_i.data.entry_key;
          move_d   = in_i.data.entry_move;
          weight_d = in_i.data.entry_weight;
          best_d   = in_i.data.prefer_best;
          rnd_d    = in_i.data.random_value;
          cnt_d    = '0;
          mism_d   = 1'b0;
          if (in_i.data.first_of_probe) begin
            active_d = 1'b1;
            max_d    = '0;
            sum_d    = '0;
            kept_d   = '0;
          end
          if (in_i.data.first_of_probe || active_q) begin
            state_d = bewp_pkg::StCmp;
          end
        end
      end

      bewp_pkg::StCmp: begin
        mism_d = mism_now;
        tkey_d = tkey_q >> DW;
        ekey_d = ekey_q >> DW;
        cnt_d  = cnt_q + DCW'(1);
        if (cnt_q == DCW'(bewp_pkg::KeyDigits - 1)) begin
          if (mism_now) begin
            state_d = bewp_pkg::StEmit;
          end else if (move_q == '0) begin
            state_d = bewp_pkg::StIdle;
          end else begin
            state_d = bewp_pkg::StUpd;
          end
        end
      end

      bewp_pkg::StUpd: begin
        max_d   = new_max;
        sum_d   = new_sum;
        state_d = bewp_pkg::StIdle;
        if (best_q) begin
          if (weight_q == new_max) begin
            kept_d = move_q;
          end
        end else if (new_sum == '0) begin
          if (kept_q == '0) begin
            kept_d = move_q;
          end
        end else if (new_sum[SumW-1:ModW] != '0) begin
          // sum beyond the random range: remainder is the random value itself
          if (weight_q > rnd_q) begin
            kept_d = move_q;
          end
        end else begin
          mod_req.start = 1'b1;
          state_d       = bewp_pkg::StMod;
        end
      end

      bewp_pkg::StMod: begin
        if (mod_rsp.done) begin
          if (weight_q > mod_rsp.remainder) begin
            kept_d = move_q;
          end
          state_d = bewp_pkg::StIdle;
        end
      end

      bewp_pkg::StEmit: begin
        // wait for a free output register
        if (!out_valid_q || out_o.ready) begin
          out_load           = 1'b1;
          out_d.chosen_move  = kept_q;
          out_d.found        = (kept_q != '0);
          out_d.weight_total = sum_q;
          active_d           = 1'b0;
          state_d            = bewp_pkg::StIdle;
        end
      end

      default: begin
        state_d = bewp_pkg::StIdle;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bewp_pkg::StIdle;
      active_q    <= 1'b0;
      max_q       <= '0;
      sum_q       <= '0;
      kept_q      <= '0;
      cnt_q       <= '0;
      mism_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      kept_q      <= kept_d;
      cnt_q       <= cnt_d;
      mism_q      <= mism_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    tkey_q   <= tkey_d;
    ekey_q   <= ekey_d;
    move_q   <= move_d;
    weight_q <= weight_d;
    best_q   <= best_d;
    rnd_q    <= rnd_d;
    out_q    <= out_d;
  end

  // checks
  `BEWP_ASSERT_IMP(a_found_matches_move, clk_i, rst_ni, out_valid_q,
                   out_q.found == (out_q.chosen_move != '0))
  `BEWP_ASSERT_IMP(a_sum_capped, clk_i, rst_ni, 1'b1, sum_q <= bewp_pkg::SumCap)
  `BEWP_ASSERT_IMP(a_mod_done_in_mod, clk_i, rst_ni, mod_rsp.done,
                   state_q == bewp_pkg::StMod)
  `BEWP_ASSERT_NXT(a_emit_ends_probe, clk_i, rst_ni, out_load,
                   out_valid_q && !active_q)

endmodule

FILE: tb/sv/bewp_pick_checker.sv
// Checker for the book entry weighted pick block: predicts pick words and compares them.
module bewp_pick_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bewp_in_if   in_i,
  bewp_out_if  out_o,
  output int   pending_o,
  output int   fail_count_o,
  output int   picks_o,
  output int   found_o
);

  // saturation point of the running sum, from the entries-per-key limit
  localparam longint unsigned EntriesPerKey = 256;
  localparam longint unsigned CapWide       = EntriesPerKey * 65535;
  localparam logic [23:0] SumLimit = (CapWide > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(CapWide);

  // predicted probe state
  logic        probe_open;
  logic [15:0] peak_weight;
  logic [23:0] sum_so_far;
  logic [15:0] held_move;
  bewp_pkg::out_word_t expected_picks[$];

  task automatic report_mismatch(input string what);
    fail_count_o++;
    $display("[%0t] pick check: %s", $time, what);
  endtask

  // fold one accepted entry word into the predicted state
  task automatic score_entry(input bewp_pkg::in_word_t w);
    logic [24:0] grown;
    logic [23:0] rem;
    bewp_pkg::out_word_t pick;
    if (w.first_of_probe) begin
      probe_open  = 1'b1;
      peak_weight = '0;
      sum_so_far  = '0;
      held_move   = '0;
    end
    if (!probe_open) return;
    // key mismatch closes the probe
    if (w.entry_key != w.target_key) begin
      pick.chosen_move  = held_move;
      pick.found        = (held_move != '0);
      pick.weight_total = sum_so_far;
      expected_picks.insert(expected_picks.size(), pick);
      probe_open = 1'b0;
      return;
    end
    // null move is skipped entirely
    if (w.entry_move == '0) return;
    if (w.entry_weight > peak_weight) peak_weight = w.entry_weight;
    grown = {1'b0, sum_so_far} + 25'(w.entry_weight);
    sum_so_far = (grown > 25'(SumLimit)) ? SumLimit : grown[23:0];
    if (w.prefer_best) begin
      // latest entry at the running max wins
      if (w.entry_weight == peak_weight) held_move = w.entry_move;
    end else if (sum_so_far != '0) begin
      rem = 24'(w.random_value) % sum_so_far;
      if (24'(w.entry_weight) > rem) held_move = w.entry_move;
    end else if (held_move == '0) begin
      // zero sum: first non-null entry is kept
      held_move = w.entry_move;
    end
  endtask

  task automatic check_pick(input bewp_pkg::out_word_t got);
    bewp_pkg::out_word_t want;
    picks_o++;
    if (got.found) found_o++;
    if (expected_picks.size() == 0) begin
      report_mismatch($sformatf("unexpected pick word move=%h found=%b total=%h",
                                got.chosen_move, got.found, got.weight_total));
      return;
    end
    want = expected_picks.pop_front();
    if (got.chosen_move !== want.chosen_move)
      report_mismatch($sformatf("chosen_move got %h want %h", got.chosen_move,
                                want.chosen_move));
    if (got.found !== want.found)
      report_mismatch($sformatf("found got %b want %b", got.found, want.found));
    if (got.weight_total !== want.weight_total)
      report_mismatch($sformatf("weight_total got %h want %h", got.weight_total,
                                want.weight_total));
  endtask

  // outputs first: a pick word never belongs to an entry taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_open  = 1'b0;
      peak_weight = '0;
      sum_so_far  = '0;
      held_move   = '0;
      expected_picks.delete();
      pending_o = 0;
    end else begin
      if (out_o.valid && out_o.ready) check_pick(out_o.data);
      if (in_i.valid && in_i.ready) score_entry(in_i.data);
      pending_o = expected_picks.size();
    end
  end

endmodule

FILE: tb/sv/tb_book_entry_weighted_pick_top.sv
// Testbench top for the book entry weighted pick block: stimulus, flow control and verdict.
module tb_book_entry_weighted_pick_top;

  logic clk_i;
  logic rst_ni;

  bewp_in_if  entry_if ();
  bewp_out_if pick_if ();

  int fail_count;
  int picks_checked;
  int moves_found;
  int picks_pending;
  int entries_sent;
  int noise_sent;
  int probes_run;
  int heavy_entries;
  bit sender_calm;

  book_entry_weighted_pick_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (entry_if),
    .out_o  (pick_if)
  );

  bewp_pick_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (entry_if),
    .out_o        (pick_if),
    .pending_o    (picks_pending),
    .fail_count_o (fail_count),
    .picks_o      (picks_checked),
    .found_o      (moves_found)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("book_entry_weighted_pick_top regression: fail");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rand_move();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return 16'h0000;
    if (r < 15) return 16'hFFFF;
    return 16'($urandom_range(65535, 1));
  endfunction

  // small weights keep the modulo meaningful, the rest covers the full range
  function automatic logic [15:0] rand_weight();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    if (r < 55) return 16'($urandom_range(15, 1));
    if (r < 75) return 16'($urandom_range(300, 16));
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic bewp_pkg::in_word_t entry(input logic first, input logic [63:0] target,
                                               input logic [63:0] key,
                                               input logic [15:0] move,
                                               input logic [15:0] weight, input logic best,
                                               input logic [15:0] rnd);
    bewp_pkg::in_word_t w;
    w.first_of_probe = first;
    w.target_key     = target;
    w.entry_key      = key;
    w.entry_move     = move;
    w.entry_weight   = weight;
    w.prefer_best    = best;
    w.random_value   = rnd;
    return w;
  endfunction

  // offer one word from a falling edge and return at the falling edge after it is taken
  task automatic drive_entry(input bewp_pkg::in_word_t w, input bit counted);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      entry_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    entry_if.valid <= 1'b1;
    entry_if.data  <= w;
    do @(posedge clk_i); while (!entry_if.ready);
    @(negedge clk_i);
    if (counted) entries_sent++;
    else noise_sent++;
  endtask

  // a run of matching entries closed by a mismatching one; optional restart inside
  task automatic run_probe(input int n_match, input int mode, input int restart_at,
                           input bit heavy);
    logic [63:0] target;
    logic [63:0] miss;
    logic [15:0] move;
    logic [15:0] weight;
    logic        best;
    int          i;
    target = rand_key();
    probes_run++;
    sender_calm = ($urandom_range(3, 0) == 0);
    for (i = 0; i < n_match; i++) begin
      if (i == restart_at && $urandom_range(1, 0)) target = rand_key();
      best   = (mode == 0) ? 1'b1 : (mode == 1) ? 1'b0 : 1'($urandom_range(1, 0));
      move   = heavy ? 16'($urandom_range(65535, 1)) : rand_move();
      weight = heavy ? 16'hFFFF : rand_weight();
      drive_entry(entry(i == 0 || i == restart_at, target, target, move, weight, best,
                        16'($urandom())), 1'b1);
      if (heavy) heavy_entries++;
    end
    // near misses exercise every key digit
    miss = $urandom_range(1, 0) ? target ^ (64'd1 << $urandom_range(63, 0)) : rand_key();
    if (miss == target) miss = ~target;
    drive_entry(entry(n_match == 0, target, miss, rand_move(), rand_weight(),
                      1'($urandom_range(1, 0)), 16'($urandom())), 1'b1);
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int  cyc;
    int  stall_left;
    bit  calm;
    bit  held_off;
    cyc        = 0;
    stall_left = 0;
    calm       = 1'b0;
    held_off   = 1'b0;
    pick_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 200 == 0) calm = ($urandom_range(3, 0) == 0);
      if (!held_off && cyc == 3000) begin
        // long hold-off: block fills up and backs up the entry side
        pick_if.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        held_off = 1'b1;
      end else if (stall_left > 0) begin
        pick_if.ready <= 1'b0;
        stall_left--;
      end else if (calm) begin
        pick_if.ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(99, 0) < 30) ? pick_gap() : 0;
        pick_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [63:0] t;
    int          pick;
    int          n;
    bit          saturated;
    saturated      = 1'b0;
    sender_calm    = 1'b0;
    entry_if.valid = 1'b0;
    entry_if.data  = '0;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no probe open: word is ignored
    drive_entry(entry(1'b0, '1, '1, '1, '1, 1'b1, '1), 1'b0);
    // mismatch on the very first word
    drive_entry(entry(1'b1, '0, '1, 16'h1234, 16'h0010, 1'b1, 16'h0000), 1'b1);

    // best mode: null move skipped, tie at max keeps the latest
    t = '1;
    drive_entry(entry(1'b1, t, t, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0001, 16'h0000, 1'b1, 16'h0000), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0000, 16'hFFFF, 1'b1, 16'h0000), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0002, 16'hFFFF, 1'b1, 16'h0000), 1'b1);
    drive_entry(entry(1'b0, t, t ^ 64'd1, 16'h0000, 16'h0000, 1'b1, 16'h0000), 1'b1);

    // random mode: zero sum keeps first, then modulo decides
    t = '0;
    drive_entry(entry(1'b1, t, t, 16'h0005, 16'h0000, 1'b0, 16'h0000), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0006, 16'h0000, 1'b0, 16'hFFFF), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0007, 16'h0003, 1'b0, 16'hFFFF), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0008, 16'h0000, 1'b0, 16'hFFFF), 1'b1);
    drive_entry(entry(1'b0, t, t ^ (64'd1 << 63), 16'h0000, 16'h0000, 1'b0, 16'h0000),
                1'b1);

    // sum beyond 16 bits in random mode, then a best-mode word in the same probe
    t = 64'h0123_4567_89AB_CDEF;
    drive_entry(entry(1'b1, t, t, 16'h0101, 16'hFFFF, 1'b0, 16'hFFFF), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0202, 16'hFFFF, 1'b0, 16'hFFFF), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0303, 16'h8000, 1'b0, 16'h7FFF), 1'b1);
    drive_entry(entry(1'b0, t, t, 16'h0404, 16'h8000, 1'b1, 16'h0000), 1'b1);

    // restart in the middle of a probe with a new key
    drive_entry(entry(1'b1, ~t, ~t, 16'h0505, 16'h0001, 1'b1, 16'h0000), 1'b1);
    drive_entry(entry(1'b0, ~t, t, 16'h0000, 16'h0000, 1'b0, 16'h0000), 1'b1);

    // random probes; one heavy run drives the sum into saturation
    while (entries_sent + noise_sent < 500) begin
      if (!saturated && entries_sent >= 150) begin
        run_probe(270, 2, -1, 1'b1);
        saturated = 1'b1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        // noise between probes
        sender_calm = 1'b0;
        repeat ($urandom_range(3, 1))
          drive_entry(entry(1'b0, rand_key(), rand_key(), rand_move(), rand_weight(),
                            1'($urandom_range(1, 0)), 16'($urandom())), 1'b0);
      end else if (pick < 25) begin
        n = $urandom_range(8, 2);
        run_probe(n, $urandom_range(2, 0), $urandom_range(n - 1, 1), 1'b0);
      end else begin
        pick = $urandom_range(99, 0);
        n = (pick < 5) ? 0 : (pick < 80) ? $urandom_range(6, 1) : $urandom_range(20, 7);
        run_probe(n, $urandom_range(2, 0), -1, 1'b0);
      end
    end
    entry_if.valid <= 1'b0;

    // drain outstanding picks, then allow for a late extra word
    wait (picks_pending == 0);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d entry words (%0d ignored, %0d in the saturating run) in %0d probes.",
             entries_sent, noise_sent, heavy_entries, probes_run);
    $display("Compared %0d pick words, %0d with a move found, %0d mismatches.",
             picks_checked, moves_found, fail_count);
    if (fail_count == 0) begin
      $display("book_entry_weighted_pick_top regression: pass");
    end else begin
      $display("book_entry_weighted_pick_top regression: fail");
    end
    $finish;
  end

endmodule
